FILE: sv/asf_pkg.sv
// shared constants, register indexes and helpers of the asymmetric slide filter
package asf_pkg;

  localparam int unsigned NCH        = 2;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned HIST_EXTRA = 16;
  localparam int unsigned HIST_W     = SAMPLE_W + HIST_EXTRA;
  localparam int unsigned SLIDE_FRAC = 8;
  localparam int unsigned SLIDE_W    = 16 + SLIDE_FRAC;
  localparam int unsigned WORK_FRAC  = SLIDE_FRAC + HIST_EXTRA;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned BLEN_W     = 13;
  localparam int unsigned TDATA_W    = NCH * SAMPLE_W;

  localparam int unsigned MAX_BLOCK_DEF = 4096;

  // channel divider: quotient never exceeds the history step magnitude
  localparam int unsigned CDIV_Q_W = HIST_W + 1;
  localparam int unsigned CDIV_N_W = CDIV_Q_W + WORK_FRAC;
  localparam int unsigned CDIV_D_W = CDIV_N_W + 1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SLIDE_UP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLIDE_DOWN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN  = 2'd2;

  localparam logic [SLIDE_W-1:0]  SLIDE_RESET = SLIDE_W'(1) << SLIDE_FRAC;
  localparam logic [BLEN_W-1:0]   BLEN_RESET  = BLEN_W'(64);
  localparam logic [ACC_W-1:0]    SLIDE_ONE   = ACC_W'(1) << WORK_FRAC;
  localparam logic [CDIV_D_W-1:0] CDEN_CAP    = CDIV_D_W'(1) << CDIV_N_W;

  // slide register to working Q16.24, clamped to at least one
  function automatic logic [ACC_W-1:0] target_of(input logic [SLIDE_W-1:0] r);
    logic [ACC_W-1:0] t;
    t = ACC_W'(r) << HIST_EXTRA;
    if (r[SLIDE_W-1:SLIDE_FRAC] == '0) begin
      t = SLIDE_ONE;
    end
    return t;
  endfunction

endpackage

FILE: sv/asymmetric_slide_filter.sv
// Asymmetric slide filter: each stereo frame moves every channel's history toward
// its input by the difference over the rising or falling slide, with both slides
// ramping linearly to their targets over each block of block_length frames. One
// frame is in work at a time. Each frame waits on the 33-step serial channel
// dividers (one per channel, running side by side); the first frame of each ramp
// block also waits on the two 64-step serial ramp dividers, which run before
// it. The output beat sits in a register, so the next frame is taken while a
// result still waits.
module asymmetric_slide_filter
  import asf_pkg::*;
#(
  parameter int unsigned MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [SLIDE_W-1:0]   cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TDATA_W-1:0]   s_axis_tdata,   // left_in, right_in
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TDATA_W-1:0]   m_axis_tdata    // left_out, right_out
);

  localparam int unsigned LEN_W = $clog2(MAX_BLOCK + 1);
  localparam int unsigned EXT_W = BLEN_W + LEN_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RAMP = 3'd1;
  localparam logic [2:0] ST_STEP = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [SLIDE_W-1:0] slide_up_q, slide_down_q;
  logic [BLEN_W-1:0]  blen_q;
  logic [2:0]         state_q, state_d;
  logic [LEN_W-1:0]   pos_q, len;
  logic [EXT_W-1:0]   blen_ext;
  logic               last_frame;

  // index 0 rising, index 1 falling
  logic [ACC_W-1:0] now_q [2];
  logic [ACC_W-1:0] inc_q [2];
  logic [ACC_W-1:0] tgt   [2];
  logic [ACC_W-1:0] rdiff [2];
  logic [ACC_W-1:0] rmag  [2];
  logic [ACC_W-1:0] rquo  [2];
  logic [1:0]       rdone;

  logic [SAMPLE_W-1:0] smp_q    [NCH];
  logic [HIST_W-1:0]   hist_q   [NCH];
  logic [HIST_W-1:0]   hist_new [NCH];
  logic [HIST_W-1:0]   x        [NCH];
  logic [HIST_W:0]     cdiff    [NCH];
  logic [HIST_W:0]     cmag     [NCH];
  logic [HIST_W+1:0]   cstep    [NCH];
  logic [ACC_W-1:0]    slide    [NCH];
  logic [CDIV_N_W-1:0] cnum     [NCH];
  logic [CDIV_D_W-1:0] cden     [NCH];
  logic [CDIV_Q_W-1:0] cquo     [NCH];
  logic [NCH-1:0]      cdone;

  logic                m_valid_q;
  logic [TDATA_W-1:0]  m_data_q, m_data_d;
  logic                s_acc, rstart, cstart, out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign rstart        = s_acc && (pos_q == '0);
  assign cstart        = (state_q == ST_LOAD);
  assign out_free      = !m_valid_q || m_axis_tready;

  // block length, zero counts as one, clamped to the maximum
  assign blen_ext = EXT_W'(blen_q);
  always_comb begin
    if (blen_q == '0) begin
      len = LEN_W'(1);
    end else if (blen_ext > EXT_W'(MAX_BLOCK)) begin
      len = LEN_W'(MAX_BLOCK);
    end else begin
      len = LEN_W'(blen_q);
    end
  end

  assign last_frame = ({1'b0, pos_q} + (LEN_W+1)'(1)) >= {1'b0, len};

  assign tgt[0] = target_of(slide_up_q);
  assign tgt[1] = target_of(slide_down_q);

  for (genvar g = 0; g < 2; g++) begin : g_ramp
    assign rdiff[g] = tgt[g] - now_q[g];
    assign rmag[g]  = rdiff[g][ACC_W-1] ? -rdiff[g] : rdiff[g];

    asf_serdiv #(
      .N_W(ACC_W),
      .D_W(LEN_W),
      .Q_W(ACC_W)
    ) u_rdiv (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(rstart),
      .num_i  (rmag[g]),
      .den_i  (len),
      .done_o (rdone[g]),
      .quo_o  (rquo[g])
    );
  end

  for (genvar c = 0; c < NCH; c++) begin : g_chan
    assign x[c]     = {smp_q[c], {HIST_EXTRA{1'b0}}};
    assign cdiff[c] = {x[c][HIST_W-1], x[c]} - {hist_q[c][HIST_W-1], hist_q[c]};
    assign cmag[c]  = cdiff[c][HIST_W] ? -cdiff[c] : cdiff[c];
    assign cnum[c]  = {cmag[c], {WORK_FRAC{1'b0}}};

    always_comb begin
      slide[c] = ($signed(x[c]) > $signed(hist_q[c])) ? now_q[0] : now_q[1];
      if ($signed(slide[c]) < $signed(SLIDE_ONE)) begin
        slide[c] = SLIDE_ONE;
      end
      // anything above the largest numerator gives a zero quotient
      if (|slide[c][ACC_W-2:CDIV_N_W]) begin
        cden[c] = CDEN_CAP;
      end else begin
        cden[c] = slide[c][CDIV_D_W-1:0];
      end
    end

    asf_serdiv #(
      .N_W(CDIV_N_W),
      .D_W(CDIV_D_W),
      .Q_W(CDIV_Q_W)
    ) u_cdiv (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(cstart),
      .num_i  (cnum[c]),
      .den_i  (cden[c]),
      .done_o (cdone[c]),
      .quo_o  (cquo[c])
    );

    assign cstep[c]    = cdiff[c][HIST_W] ? -{1'b0, cquo[c]} : {1'b0, cquo[c]};
    assign hist_new[c] = hist_q[c] + cstep[c][HIST_W-1:0];
    assign m_data_d[c*SAMPLE_W +: SAMPLE_W] = hist_new[c][HIST_W-1:HIST_EXTRA];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          state_d = rstart ? ST_RAMP : ST_STEP;
        end
      end
      ST_RAMP: begin
        if (&rdone) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (&cdone) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slide_up_q   <= SLIDE_RESET;
      slide_down_q <= SLIDE_RESET;
      blen_q       <= BLEN_RESET;
      pos_q        <= '0;
      m_valid_q    <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        now_q[i] <= SLIDE_ONE;
        inc_q[i] <= '0;
      end
      for (int i = 0; i < NCH; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_SLIDE_UP:   slide_up_q   <= cfg_wdata_i;
          REG_SLIDE_DOWN: slide_down_q <= cfg_wdata_i;
          REG_BLOCK_LEN:  blen_q       <= cfg_wdata_i[BLEN_W-1:0];
          default: ;
        endcase
      end

      if (state_q == ST_RAMP && (&rdone)) begin
        for (int i = 0; i < 2; i++) begin
          inc_q[i] <= rdiff[i][ACC_W-1] ? -rquo[i] : rquo[i];
        end
      end

      if (state_q == ST_STEP) begin
        for (int i = 0; i < 2; i++) begin
          now_q[i] <= last_frame ? tgt[i] : now_q[i] + inc_q[i];
        end
        pos_q <= last_frame ? '0 : pos_q + LEN_W'(1);
      end

      if (state_q == ST_FIN && out_free) begin
        for (int i = 0; i < NCH; i++) begin
          hist_q[i] <= hist_new[i];
        end
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      for (int i = 0; i < NCH; i++) begin
        smp_q[i] <= s_axis_tdata[i*SAMPLE_W +: SAMPLE_W];
      end
    end
    if (state_q == ST_FIN && out_free) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: sv/asf_serdiv.sv
// radix-2 restoring divider, one quotient bit per cycle
module asf_serdiv #(
  parameter int unsigned N_W = 64,
  parameter int unsigned D_W = 13,
  parameter int unsigned Q_W = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  output logic           done_o,
  output logic [Q_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(Q_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [D_W-1:0]   rem_q, rem_d, den_q, rem_init;
  logic [Q_W-1:0]   sh_q;
  logic [D_W:0]     trial, diff;
  logic             ge;

  // upper numerator bits are known to stay below the divisor
  if (N_W > Q_W) begin : g_init
    assign rem_init = D_W'(num_i[N_W-1:Q_W]);
  end else begin : g_zero
    assign rem_init = '0;
  end

  assign trial = {rem_q, sh_q[Q_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? diff[D_W-1:0] : trial[D_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(Q_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init;
      sh_q  <= num_i[Q_W-1:0];
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[Q_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

FILE: sv/asf_checker.sv
// port-level checks of the asymmetric slide filter, bound to the top level
module asf_checker
  import asf_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [TDATA_W-1:0]   m_axis_tdata
);

  logic s_beat;
  assign s_beat = s_axis_tvalid && s_axis_tready;

  // a stalled result beat keeps its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // one frame in work at a time
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken while a frame is in work");

  // a new result only comes at the end of a frame's work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result beat without a frame in work");

endmodule

bind asymmetric_slide_filter asf_checker u_asf_checker (.*);

FILE: verif/asymmetric_slide_filter_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the asymmetric slide filter with its own predictor

module asymmetric_slide_filter_tb;
  import asf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 800_000;
  localparam longint      SLIDE_UNIT  = longint'(1) << WORK_FRAC;

  typedef struct packed {
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] left;
  } frame_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i = REG_SLIDE_UP;
  logic [SLIDE_W-1:0]   cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata = '0;   // left_in, right_in
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;        // left_out, right_out

  asymmetric_slide_filter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state, reset values of the block
  logic [SLIDE_W-1:0] up_reg   = SLIDE_RESET;
  logic [SLIDE_W-1:0] down_reg = SLIDE_RESET;
  logic [BLEN_W-1:0]  blen_reg = BLEN_RESET;
  longint history [NCH] = '{0, 0};
  longint rise_now = SLIDE_UNIT;
  longint fall_now = SLIDE_UNIT;
  longint rise_inc = 0;
  longint fall_inc = 0;
  longint frame_pos = 0;

  frame_t in_frames_q [$];
  frame_t smoothed_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  logic        hold_off = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned frames_sent = 0;
  int unsigned frames_checked = 0;
  int unsigned configs_used = 0;

  function automatic longint slide_goal(input logic [SLIDE_W-1:0] r);
    longint t;
    t = longint'(r) << HIST_EXTRA;
    if (t < SLIDE_UNIT) begin
      t = SLIDE_UNIT;
    end
    return t;
  endfunction

  function automatic longint ramp_incr(input longint goal, input longint now, input longint len);
    longint d;
    longint mag;
    d = goal - now;
    mag = ((d < 0) ? -d : d) / len;
    return (d < 0) ? -mag : mag;
  endfunction

  function automatic logic [SAMPLE_W-1:0] smooth_channel(input int ch,
                                                          input logic [SAMPLE_W-1:0] raw);
    longint      x;
    longint      d;
    longint      slide;
    longint      move;
    logic [63:0] mag;
    logic [63:0] h;
    x = longint'($signed(raw)) * (longint'(1) << HIST_EXTRA);
    slide = (x > history[ch]) ? rise_now : fall_now;
    if (slide < SLIDE_UNIT) begin
      slide = SLIDE_UNIT;
    end
    d = x - history[ch];
    mag = (d < 0) ? -d : d;
    mag = (mag << WORK_FRAC) / 64'(slide);
    move = (d < 0) ? -longint'(mag) : longint'(mag);
    history[ch] = history[ch] + move;
    h = history[ch];
    return h[HIST_W-1:HIST_EXTRA];
  endfunction

  function automatic frame_t smooth_frame(input frame_t f);
    longint goal_up;
    longint goal_down;
    longint len;
    frame_t r;
    goal_up = slide_goal(up_reg);
    goal_down = slide_goal(down_reg);
    if (blen_reg == 0) begin
      len = 1;
    end else if (blen_reg > MAX_BLOCK_DEF) begin
      len = MAX_BLOCK_DEF;
    end else begin
      len = blen_reg;
    end
    if (frame_pos == 0) begin
      rise_inc = ramp_incr(goal_up, rise_now, len);
      fall_inc = ramp_incr(goal_down, fall_now, len);
    end
    rise_now = rise_now + rise_inc;
    fall_now = fall_now + fall_inc;
    if (frame_pos + 1 >= len) begin
      rise_now = goal_up;
      fall_now = goal_down;
      frame_pos = 0;
    end else begin
      frame_pos = frame_pos + 1;
    end
    r.left = smooth_channel(0, f.left);
    r.right = smooth_channel(1, f.right);
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic offer;
    if (s_axis_tvalid && s_axis_tready) begin
      smoothed_q.push_back(smooth_frame(in_frames_q[0]));
      void'(in_frames_q.pop_front());
      frames_sent++;
    end
    if (s_axis_tvalid && !s_axis_tready) begin
      offer = 1'b1;
    end else begin
      offer = (in_frames_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
    end
    s_axis_tvalid <= offer;
    if (offer) begin
      s_axis_tdata <= in_frames_q[0];
    end
  end

  // monitor
  always @(posedge clk_i) begin
    frame_t got;
    frame_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      frames_checked++;
      if (smoothed_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected beat, expected none actual %h", $time, got);
      end else begin
        want = smoothed_q.pop_front();
        if (got.left !== want.left) begin
          err_cnt++;
          $display("%0t: left_out mismatch, expected %h actual %h", $time, want.left, got.left);
        end
        if (got.right !== want.right) begin
          err_cnt++;
          $display("%0t: right_out mismatch, expected %h actual %h", $time, want.right,
                   got.right);
        end
      end
    end
    m_axis_tready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, smoothed_q.size());
      $display("asymmetric_slide_filter_tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SLIDE_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_SLIDE_UP: up_reg = val;
      REG_SLIDE_DOWN: down_reg = val;
      REG_BLOCK_LEN: blen_reg = val[BLEN_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_all(input logic [SLIDE_W-1:0] up, input logic [SLIDE_W-1:0] down,
                             input logic [SLIDE_W-1:0] len);
    write_reg(REG_SLIDE_UP, up);
    write_reg(REG_SLIDE_DOWN, down);
    write_reg(REG_BLOCK_LEN, len);
    configs_used++;
  endtask

  task automatic settle();
    while (in_frames_q.size() != 0 || smoothed_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic push_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
    frame_t f;
    f.left = l;
    f.right = r;
    in_frames_q.push_back(f);
  endtask

  function automatic logic [SAMPLE_W-1:0] edge_sample();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [SLIDE_W-1:0] pick_slide();
    case ($urandom_range(5))
      0: return '0;
      1: return SLIDE_W'($urandom_range(255));
      2: return SLIDE_RESET;
      3: return SLIDE_W'($urandom);
      4: return SLIDE_W'($urandom_range(257, 4096));
      default: return '1;
    endcase
  endfunction

  function automatic logic [SLIDE_W-1:0] pick_len();
    case ($urandom_range(5))
      0: return '0;
      1: return SLIDE_W'(1);
      2: return SLIDE_W'($urandom_range(2, 16));
      3: return SLIDE_W'($urandom_range(17, 200));
      4: return SLIDE_W'(MAX_BLOCK_DEF);
      default: return SLIDE_W'($urandom_range(MAX_BLOCK_DEF + 1, 8191));
    endcase
  endfunction

  // level steps held for a while, bursts of noise, full-scale jumps
  task automatic queue_frames(input int n);
    int               added;
    int               run;
    int               mode;
    logic [SAMPLE_W-1:0] l;
    logic [SAMPLE_W-1:0] r;
    added = 0;
    while (added < n) begin
      mode = $urandom_range(9);
      run = (mode < 6) ? $urandom_range(4, 24) : $urandom_range(1, 8);
      l = SAMPLE_W'($urandom);
      r = SAMPLE_W'($urandom);
      if (mode < 2) begin
        l = edge_sample();
        r = edge_sample();
      end
      for (int i = 0; i < run && added < n; i++) begin
        if (mode >= 8) begin
          l = edge_sample();
          r = edge_sample();
        end else if (mode >= 6) begin
          l = SAMPLE_W'($urandom);
          r = SAMPLE_W'($urandom);
        end
        push_frame(l, r);
        added++;
      end
    end
  endtask

  initial begin
    int unsigned idle_tbl  [4];
    int unsigned stall_tbl [4];
    idle_tbl  = '{0, 50, 0, 9};
    stall_tbl = '{0, 0, 50, 9};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, unit slides follow the input exactly
    push_frame(16'h7FFF, 16'h8000);
    push_frame(16'h8000, 16'h7FFF);
    push_frame(16'h0000, 16'h0000);
    push_frame(16'hFFFF, 16'h0001);
    push_frame(16'h7FFF, 16'h7FFF);
    push_frame(16'h8000, 16'h8000);
    push_frame(16'h0001, 16'hFFFF);
    push_frame(16'h7FFF, 16'h8000);
    settle();

    // targets below one, zero block length
    program_all('0, SLIDE_W'(8'h80), '0);
    push_frame(16'h8000, 16'h7FFF);
    push_frame(16'h7FFF, 16'h8000);
    push_frame(16'h1234, 16'hEDCB);
    push_frame(16'h8000, 16'h8000);
    settle();

    // widest rising slide, block ends part way through
    program_all('1, SLIDE_RESET, SLIDE_W'(3));
    push_frame(16'h7FFF, 16'h7FFF);
    push_frame(16'h8000, 16'h8000);
    push_frame(16'h7FFF, 16'h0000);
    push_frame(16'h4000, 16'hC000);
    push_frame(16'h8000, 16'h7FFF);
    settle();

    // block shortened mid block
    write_reg(REG_BLOCK_LEN, SLIDE_W'(2));
    push_frame(16'h7FFF, 16'h8000);
    push_frame(16'h0000, 16'h7FFF);
    settle();

    // targets moved mid block
    write_reg(REG_SLIDE_DOWN, '1);
    write_reg(REG_SLIDE_UP, SLIDE_W'(24'h000180));
    push_frame(16'h8000, 16'h7FFF);
    push_frame(16'h7FFF, 16'h8000);
    push_frame(16'h0000, 16'h0000);
    settle();

    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0) begin
        program_all('1, '0, SLIDE_W'(MAX_BLOCK_DEF));
      end else if (phase == 1) begin
        program_all('0, '1, SLIDE_W'(8191));
      end else begin
        if ($urandom_range(9) < 7) write_reg(REG_SLIDE_UP, pick_slide());
        if ($urandom_range(9) < 7) write_reg(REG_SLIDE_DOWN, pick_slide());
        write_reg(REG_BLOCK_LEN, pick_len());
        configs_used++;
      end
      send_idle_pct <= idle_tbl[phase % 4];
      sink_stall_pct <= stall_tbl[phase % 4];
      queue_frames(70);
      settle();
    end

    // output side held off long enough for the input to back up
    send_idle_pct <= 0;
    sink_stall_pct <= 0;
    program_all(SLIDE_W'(24'h000300), SLIDE_W'(24'h000140), SLIDE_W'(5));
    queue_frames(50);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
    settle();

    repeat (150) @(posedge clk_i);
    if (smoothed_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected beats never arrived", $time, smoothed_q.size());
    end
    $display("frames in: %0d, results checked: %0d, register settings: %0d, errors: %0d",
             frames_sent, frames_checked, configs_used, err_cnt);
    $display("covered full-scale steps, sub-unit and widest slides, out-of-range block lengths");
    if (err_cnt == 0) begin
      $display("asymmetric_slide_filter_tb: PASS");
    end else begin
      $display("asymmetric_slide_filter_tb: FAIL");
    end
    $finish;
  end

endmodule
